@@ rtl/rsprs_pkg.sv @@
// ----------------------------------------------------------------------------
// rsprs_pkg
// Shared types and constants of the radix string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rsprs_pkg;

   localparam int VALUE_W    = 64;
   localparam int OUT_W      = 64;
   localparam int CHAR_W     = 8;
   localparam int RADIX_W    = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHR_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHR_LOW_F = 8'h66;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic               SMODE_RESET = 1'b1;

   typedef enum logic {
      REG_RADIX = 1'b0,
      REG_SMODE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic               signed_mode;
   } cfg_type;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             ok;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/rsprs_csr.sv @@
// ----------------------------------------------------------------------------
// rsprs_csr
// Configuration registers: radix and signed mode, behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsprs_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rsprs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rsprs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [rsprs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready,
   output rsprs_pkg::cfg_type                     cfg
);
   import rsprs_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;
   logic               smode_ff;
   logic               smode_in;
   logic               wr_en;
   reg_index_type      reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      radix_in = radix_ff;
      smode_in = smode_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_RADIX: radix_in = csr_pwdata[RADIX_W-1:0];
            REG_SMODE: smode_in = csr_pwdata[0];
            default:   radix_in = radix_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         smode_ff <= SMODE_RESET;
      end else begin
         radix_ff <= radix_in;
         smode_ff <= smode_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RADIX: csr_prdata = {{(CSR_DATA_W-RADIX_W){1'b0}}, radix_ff};
         REG_SMODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, smode_ff};
         default:   csr_prdata = '0;
      endcase
   end

   assign cfg.radix       = radix_ff;
   assign cfg.signed_mode = smode_ff;

endmodule

`default_nettype wire

@@ rtl/rsprs_engine.sv @@
// ----------------------------------------------------------------------------
// rsprs_engine
// Per-string state and the character step: sign handling, digit decode and
// the accumulator multiply-add; forms the result on the terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module rsprs_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [rsprs_pkg::CHAR_W-1:0]  character,
   input  wire rsprs_pkg::cfg_type            cfg,
   output rsprs_pkg::result_type              result
);
   import rsprs_pkg::*;

   typedef enum logic [1:0] {
      PH_START       = 2'd0,
      PH_AFTER_MINUS = 2'd1,
      PH_PAST_SIGNS  = 2'd2
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic                 neg_ff, neg_in;
   logic                 failed_ff, failed_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;

   logic                 is_dec, is_hex;
   logic [3:0]           digit;
   logic [VALUE_W+RADIX_W-1:0] prod;
   logic [VALUE_W-1:0]   mac;
   logic [VALUE_W-1:0]   signed_val;

   assign is_dec = (character >= CHR_ZERO) && (character <= CHR_NINE);
   assign is_hex = (character >= CHR_LOW_A) && (character <= CHR_LOW_F);

   always_comb begin
      if (is_dec) begin
         digit = 4'(character - CHR_ZERO);
      end else begin
         digit = 4'(character - CHR_LOW_A + 8'd10);
      end
   end

   assign prod = acc_ff * cfg.radix;
   assign mac  = prod[VALUE_W-1:0] + {{(VALUE_W-4){1'b0}}, digit};

   assign signed_val   = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign result.value = failed_ff ? '0 : OUT_W'(signed_val);
   assign result.ok    = !failed_ff;

   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      failed_in = failed_ff;
      acc_in    = acc_ff;
      if (step) begin
         if (character == CHR_NUL) begin
            phase_in  = PH_START;
            neg_in    = 1'b0;
            failed_in = 1'b0;
            acc_in    = '0;
         end else if (failed_ff) begin
            failed_in = 1'b1;
         end else if (cfg.signed_mode && character == CHR_MINUS && phase_ff == PH_START) begin
            neg_in   = 1'b1;
            phase_in = PH_AFTER_MINUS;
         end else if (cfg.signed_mode && character == CHR_PLUS
                      && phase_ff != PH_PAST_SIGNS) begin
            neg_in   = 1'b0;
            phase_in = PH_PAST_SIGNS;
         end else if (!(is_dec || is_hex)) begin
            failed_in = 1'b1;
         end else begin
            phase_in = PH_PAST_SIGNS;
            acc_in   = mac;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         neg_ff    <= 1'b0;
         failed_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         failed_ff <= failed_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/radix_string_parser_core.sv @@
// ----------------------------------------------------------------------------
// radix_string_parser_core
// Parses a zero-terminated byte string into a 64-bit integer in a set radix.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one string byte per beat (req_character); a zero byte ends
//   the string. rsp_ channel: one beat per terminator with rsp_value and
//   rsp_ok (rsp_value is 0 when rsp_ok is 0). Non-terminator bytes give no
//   beat. csr_ port: radix at address 0 (reset 10), signed_mode at 4
//   (reset 1); write only while no string is in flight.
//   Throughput: one byte per cycle except while a terminator is held; the
//   accumulator multiply-add and the sign logic act after the input register;
//   a terminator's result then loads the output register, raising rsp_valid.
//   Stall: a held result waits in the output register; non-terminator bytes
//   keep flowing, and a terminator stays in the input register (raising
//   req_stall) until the output register is free or taken that cycle.
//   Reset: clears both registers' valid flags and starts a fresh string;
//   configuration returns to radix 10, signed mode.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_string_parser_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [rsprs_pkg::CHAR_W-1:0]      req_character,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [rsprs_pkg::OUT_W-1:0]       rsp_value,
   output logic                                   rsp_ok,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rsprs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rsprs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [rsprs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready
);
   import rsprs_pkg::*;

   cfg_type            cfg;
   result_type         result;

   logic               in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]  in_char_ff, in_char_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   logic               accept;
   logic               is_term;
   logic               advance;

   rsprs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rsprs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .character (in_char_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign is_term   = (in_char_ff == CHR_NUL);
   assign advance   = in_valid_ff && (!is_term || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_char_in  = req_character;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance && is_term) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_ff.value;
   assign rsp_ok    = out_ff.ok;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.ok |-> out_ff.value == '0)
      else $error("failed result carries a nonzero value");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && is_term && out_valid_ff)
      else $error("input stalled without a blocked terminator");

   a_load_term: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff && in_char_ff == CHR_NUL))
      else $error("result beat not caused by a terminator");

endmodule

`default_nettype wire
